// ----- hw/rtl/bilinear_interpolator_defines.svh -----
// Assertion macros used by the bilinear interpolator top level.
`ifndef BILINEAR_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define BI_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define BI_ASSERT(lbl, prop, msg)
`define BI_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/bi_pkg.sv -----
// Widths, word types and pipeline flags of the bilinear interpolator.
package bi_pkg;
   localparam int COORD_BITS = 24;
   localparam int VALUE_BITS = 32;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic signed [COORD_BITS-1:0] lo_x;
      logic signed [COORD_BITS-1:0] lo_y;
      logic signed [COORD_BITS-1:0] hi_x;
      logic signed [COORD_BITS-1:0] hi_y;
      logic signed [VALUE_BITS-1:0] val_ll;
      logic signed [VALUE_BITS-1:0] val_hl;
      logic signed [VALUE_BITS-1:0] val_lh;
      logic signed [VALUE_BITS-1:0] val_hh;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] blended;
      logic                         degenerate;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic degen;
      logic ovf;
   } flag_type;
endpackage

// ----- hw/rtl/bi_front.sv -----
// Front pipeline: differences, weights, weighted sum, magnitudes, range check.
module bi_front import bi_pkg::*; #(
   parameter int C = COORD_BITS,
   parameter int V = VALUE_BITS,
   localparam int D = C + 1,
   localparam int W = 2 * D,
   localparam int S = V + W + 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [C-1:0] px,
   input  logic signed [C-1:0] py,
   input  logic signed [C-1:0] lo_x,
   input  logic signed [C-1:0] lo_y,
   input  logic signed [C-1:0] hi_x,
   input  logic signed [C-1:0] hi_y,
   input  logic signed [V-1:0] vals [4],
   output flag_type            flg_o,
   output logic        [S-1:0] num_o,
   output logic        [W-1:0] area_o
);
   localparam int H  = W / 2;
   localparam int WH = W - H;
   localparam int T  = V + W;

   logic [5:0] v_ff;

   logic signed [D-1:0] ax_ff, bx_ff, ay_ff, by_ff, dx_ff, dy_ff;
   logic signed [V-1:0] val1_ff [4];
   logic signed [V-1:0] val2_ff [4];
   logic signed [W-1:0] w2_ff [4];
   logic signed [W-1:0] ar2_ff, ar3_ff, ar4_ff, ar5_ff;
   logic signed [V+H:0]    plo_ff [4];
   logic signed [V+WH-1:0] phi_ff [4];
   logic signed [T-1:0] t_ff [4];
   logic signed [S-1:0] acc_ff;
   logic        [S-1:0] num6_ff;
   logic        [W-1:0] area6_ff;
   logic                neg6_ff, degen6_ff;
   flag_type            flg_ff;
   logic        [S-1:0] num_ff;
   logic        [W-1:0] area_ff;

   logic        [S-1:0] lim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         flg_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:0], in_valid};
         flg_ff.valid <= v_ff[5];
         flg_ff.neg <= neg6_ff;
         flg_ff.degen <= degen6_ff;
         flg_ff.ovf <= num6_ff >= lim_in;
      end
   end

   assign lim_in = S'(area6_ff) << V;

   always_ff @(posedge clock) begin
      ax_ff <= D'(hi_x) - D'(px);
      bx_ff <= D'(px) - D'(lo_x);
      ay_ff <= D'(hi_y) - D'(py);
      by_ff <= D'(py) - D'(lo_y);
      dx_ff <= D'(hi_x) - D'(lo_x);
      dy_ff <= D'(hi_y) - D'(lo_y);
      val1_ff <= vals;
      w2_ff[0] <= ax_ff * ay_ff;
      w2_ff[1] <= bx_ff * ay_ff;
      w2_ff[2] <= ax_ff * by_ff;
      w2_ff[3] <= bx_ff * by_ff;
      ar2_ff <= dx_ff * dy_ff;
      val2_ff <= val1_ff;
      for (int i = 0; i < 4; i++) begin
         plo_ff[i] <= val2_ff[i] * $signed({1'b0, w2_ff[i][H-1:0]});
         phi_ff[i] <= val2_ff[i] * $signed(w2_ff[i][W-1:H]);
         t_ff[i] <= (T'(phi_ff[i]) <<< H) + T'(plo_ff[i]);
      end
      ar3_ff <= ar2_ff;
      ar4_ff <= ar3_ff;
      acc_ff <= S'(t_ff[0]) + S'(t_ff[1]) + S'(t_ff[2]) + S'(t_ff[3]);
      ar5_ff <= ar4_ff;
      num6_ff <= acc_ff[S-1] ? S'(-acc_ff) : S'(acc_ff);
      area6_ff <= ar5_ff[W-1] ? W'(-ar5_ff) : W'(ar5_ff);
      neg6_ff <= acc_ff[S-1] ^ ar5_ff[W-1];
      degen6_ff <= ar5_ff == '0;
      num_ff <= num6_ff;
      area_ff <= area6_ff;
   end

   assign flg_o  = flg_ff;
   assign num_o  = num_ff;
   assign area_o = area_ff;
endmodule

// ----- hw/rtl/bi_div.sv -----
// Restoring divider, one quotient bit per pipeline stage.
module bi_div import bi_pkg::*; #(
   parameter int V = VALUE_BITS,
   parameter int W = 2 * (COORD_BITS + 1),
   localparam int S = V + W + 2
) (
   input  logic         clock,
   input  logic         reset,
   input  flag_type     flg_i,
   input  logic [S-1:0] num_i,
   input  logic [W-1:0] area_i,
   output flag_type     flg_o,
   output logic [V-1:0] q_o,
   output logic [W-1:0] rem_o,
   output logic [W-1:0] area_o
);
   flag_type     flg_ff  [V];
   logic [S-1:0] rem_ff  [V];
   logic [V-1:0] q_ff    [V];
   logic [W-1:0] area_ff [V];

   for (genvar k = 0; k < V; k++) begin : g_step
      localparam int B = V - 1 - k;
      flag_type     flg_p;
      logic [S-1:0] rem_p;
      logic [V-1:0] q_p;
      logic [W-1:0] area_p;
      logic [S:0]   diff_in;

      if (k == 0) begin : g_first
         assign flg_p  = flg_i;
         assign rem_p  = num_i;
         assign q_p    = '0;
         assign area_p = area_i;
      end else begin : g_next
         assign flg_p  = flg_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign q_p    = q_ff[k-1];
         assign area_p = area_ff[k-1];
      end

      assign diff_in = {1'b0, rem_p} - ((S+1)'(area_p) << B);

      always_ff @(posedge clock) begin
         if (reset) begin
            flg_ff[k] <= '0;
         end else begin
            flg_ff[k] <= flg_p;
         end
      end

      // keep the trial difference when it did not borrow
      always_ff @(posedge clock) begin
         area_ff[k] <= area_p;
         if (!diff_in[S]) begin
            rem_ff[k] <= diff_in[S-1:0];
            q_ff[k] <= q_p | (V'(1) << B);
         end else begin
            rem_ff[k] <= rem_p;
            q_ff[k] <= q_p;
         end
      end
   end

   assign flg_o  = flg_ff[V-1];
   assign q_o    = q_ff[V-1];
   assign rem_o  = rem_ff[V-1][W-1:0];
   assign area_o = area_ff[V-1];
endmodule

// ----- hw/rtl/bi_fin.sv -----
// Rounding, sign, saturation and the output register.
module bi_fin import bi_pkg::*; #(
   parameter int V = VALUE_BITS,
   parameter int W = 2 * (COORD_BITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  flag_type            flg_i,
   input  logic        [V-1:0] q_i,
   input  logic        [W-1:0] rem_i,
   input  logic        [W-1:0] area_i,
   output logic                strobe,
   output logic signed [V-1:0] blended,
   output logic                degenerate,
   output logic                saturated
);
   localparam logic [V:0] NEG_LIM = (V+1)'(1) << (V - 1);
   localparam logic [V:0] POS_LIM = NEG_LIM - (V+1)'(1);

   flag_type            flg_ff;
   logic        [V:0]   qr_ff;
   logic                strobe_ff, degen_ff, sat_ff;
   logic signed [V-1:0] res_ff;
   logic                sat_in;
   logic        [V-1:0] res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flg_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         flg_ff <= flg_i;
         strobe_ff <= flg_ff.valid;
      end
   end

   // round half away from zero on the magnitude
   always_ff @(posedge clock) begin
      qr_ff <= (V+1)'(q_i) + (V+1)'({rem_i, 1'b0} >= {1'b0, area_i});
   end

   always_comb begin
      sat_in = 1'b0;
      res_in = '0;
      if (flg_ff.degen) begin
         res_in = '0;
      end else if (flg_ff.neg) begin
         if (flg_ff.ovf || qr_ff > NEG_LIM) begin
            sat_in = 1'b1;
            res_in = NEG_LIM[V-1:0];
         end else begin
            res_in = V'(-qr_ff);
         end
      end else begin
         if (flg_ff.ovf || qr_ff > POS_LIM) begin
            sat_in = 1'b1;
            res_in = POS_LIM[V-1:0];
         end else begin
            res_in = qr_ff[V-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= $signed(res_in);
      degen_ff <= flg_ff.degen;
      sat_ff <= sat_in;
   end

   assign strobe     = strobe_ff;
   assign blended    = res_ff;
   assign degenerate = degen_ff;
   assign saturated  = sat_ff;
endmodule

// ----- hw/rtl/bilinear_interpolator.sv -----
// Bilinear interpolator top level: pipelined blend of four corner values.
// A word is taken every cycle that reset is low (busy follows reset only) and its
// result shows on rsp_data with rsp_strobe for one cycle. The pipeline holds the
// divider, which resolves one quotient bit per stage, plus seven stages of
// differences, multiplies and sums and two of rounding and saturation. The
// receiver cannot stall, so nothing ever holds.
`include "bilinear_interpolator_defines.svh"
module bilinear_interpolator import bi_pkg::*; #(
   parameter int COORD_W = COORD_BITS,
   parameter int VALUE_W = VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int W   = 2 * (COORD_W + 1);
   localparam int S   = VALUE_W + W + 2;
   localparam int LAT = VALUE_W + 9;

   logic signed [VALUE_W-1:0] vals [4];
   flag_type     f_flg, d_flg;
   logic [S-1:0] f_num;
   logic [W-1:0] f_area, d_rem, d_area;
   logic [VALUE_W-1:0] d_q;

   assign busy = reset;
   assign vals[0] = req_data.val_ll;
   assign vals[1] = req_data.val_hl;
   assign vals[2] = req_data.val_lh;
   assign vals[3] = req_data.val_hh;

   bi_front #(.C(COORD_W), .V(VALUE_W)) u_front (
      .clock, .reset,
      .in_valid(start && !busy),
      .px(req_data.px), .py(req_data.py),
      .lo_x(req_data.lo_x), .lo_y(req_data.lo_y),
      .hi_x(req_data.hi_x), .hi_y(req_data.hi_y),
      .vals,
      .flg_o(f_flg), .num_o(f_num), .area_o(f_area)
   );

   bi_div #(.V(VALUE_W), .W(W)) u_div (
      .clock, .reset,
      .flg_i(f_flg), .num_i(f_num), .area_i(f_area),
      .flg_o(d_flg), .q_o(d_q), .rem_o(d_rem), .area_o(d_area)
   );

   bi_fin #(.V(VALUE_W), .W(W)) u_fin (
      .clock, .reset,
      .flg_i(d_flg), .q_i(d_q), .rem_i(d_rem), .area_i(d_area),
      .strobe(rsp_strobe),
      .blended(rsp_data.blended),
      .degenerate(rsp_data.degenerate),
      .saturated(rsp_data.saturated)
   );

   `BI_ASSERT(a_latency, (start && !busy) |-> ##LAT rsp_strobe, "result word missing")
   `BI_ASSERT_IMPL(a_degen, rsp_strobe && rsp_data.degenerate,
      rsp_data.blended == '0 && !rsp_data.saturated, "degenerate word not zero")
   `BI_ASSERT_IMPL(a_sat, rsp_strobe && rsp_data.saturated,
      rsp_data.blended == {1'b1, {(VALUE_W-1){1'b0}}} ||
      rsp_data.blended == {1'b0, {(VALUE_W-1){1'b1}}}, "saturated word off limit")
   `BI_ASSERT_IMPL(a_quiet, $past(reset), !rsp_strobe, "strobe right after reset")
endmodule
